// ===== hw/rtl/wlra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window least-rotation anchors: shared definitions
// Field widths and the register reset value used across the block.
// ----------------------------------------------------------------------------
package wlra_pkg;

  // Widths of the words on the input, output and configuration ports.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned OFFSET_W = 6;
  localparam int unsigned ANCHOR_W = 32;

  // Window length after reset.
  localparam logic [CFG_W-1:0] LEN_RESET = 7'd16;

endpackage

// ===== hw/rtl/window_least_rotation_anchors_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window least-rotation anchors core
// Keeps the last window_length bytes of a text in a circular byte memory and,
// for every word once the window is full, runs Booth's least-rotation scan
// over the doubled window with a failure-link memory. Reports the rotation
// offset and the absolute anchor position.
// ----------------------------------------------------------------------------
// A word that leaves the window short starts no scan. For length n a scan first
// clears the failure links, then visits each of the 2n - 1 scan positions of the
// doubled window, following failure-link hops as needed, and then loads the
// result register.
// One word at a time; the next is taken while a result waits for the output.
// Reset (rst_ni low, asynchronous) clears control, fill count and position.

module window_least_rotation_anchors_core #(
  parameter int unsigned WIN_MAX  = 64,
  parameter int unsigned POS_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [wlra_pkg::CFG_W-1:0]     cfg_wdata_i,
  // Input channel.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [wlra_pkg::BYTE_W-1:0]    text_byte_i,
  input  logic                           new_text_i,
  // Output channel.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [wlra_pkg::ANCHOR_W-1:0]  anchor_position_o,
  output logic [wlra_pkg::OFFSET_W-1:0]  rotation_offset_o
);

  // Widths derived from the window size.
  localparam int unsigned WA = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
  localparam int unsigned FA = $clog2(2 * WIN_MAX);
  localparam int unsigned LW = $clog2(WIN_MAX + 1);
  localparam int unsigned JW = $clog2(2 * WIN_MAX + 1);
  localparam int unsigned IS = JW + 1;

  localparam logic signed [IS-1:0] NEG1 = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_SJ_A,
    ST_SJ_W,
    ST_LP_A,
    ST_LP_W,
    ST_LP_F,
    ST_TL_A,
    ST_TL_W,
    ST_DONE
  } state_e;

  state_e                        state_q;
  logic [wlra_pkg::CFG_W-1:0]    cfg_q;
  logic [WA-1:0]                 widx_q;
  logic [LW-1:0]                 fill_q;
  logic [POS_BITS-1:0]           pos_q;
  logic [POS_BITS-1:0]           wstart_q;
  logic [LW-1:0]                 n_q;
  logic [JW-1:0]                 nd_q;
  logic [WA-1:0]                 base_q;
  logic [JW-1:0]                 j_q;
  logic [JW-1:0]                 k_q;
  logic signed [IS-1:0]          i_q;
  logic [wlra_pkg::BYTE_W-1:0]   sj_q;
  logic                          out_valid_q;
  logic [wlra_pkg::ANCHOR_W-1:0] anchor_q;
  logic [wlra_pkg::OFFSET_W-1:0] offset_q;

  // Memories.
  logic [wlra_pkg::BYTE_W-1:0]   win_mem [WIN_MAX];
  logic [wlra_pkg::BYTE_W-1:0]   win_rdata_q;
  logic [WA-1:0]                 win_raddr;
  logic signed [IS-1:0]          fail_mem [2*WIN_MAX];
  logic signed [IS-1:0]          fail_rdata_q;
  logic [FA-1:0]                 fail_raddr;
  logic [FA-1:0]                 fail_waddr;
  logic signed [IS-1:0]          fail_wdata;
  logic                          fail_we;

  // Reduces a value below twice the window length into the window.
  function automatic logic [JW-1:0] mod_n(input logic [JW:0] v, input logic [LW-1:0] n);
    logic [JW:0] nx;
    nx = (JW+1)'(n);
    if (v >= nx) begin
      mod_n = JW'(v - nx);
    end else begin
      mod_n = JW'(v);
    end
  endfunction

  // Maps a window offset onto the circular byte memory.
  function automatic logic [WA-1:0] phys(input logic [WA-1:0] base, input logic [JW-1:0] x);
    logic [LW:0] s;
    s = (LW+1)'(base) + (LW+1)'(x);
    if (s >= (LW+1)'(WIN_MAX)) begin
      s = s - (LW+1)'(WIN_MAX);
    end
    phys = s[WA-1:0];
  endfunction

  // Effective window length: zero acts as one, oversize as the maximum.
  logic [LW-1:0] len_eff;
  always_comb begin
    if (cfg_q == '0) begin
      len_eff = LW'(1);
    end else if (int'(cfg_q) > int'(WIN_MAX)) begin
      len_eff = LW'(WIN_MAX);
    end else begin
      len_eff = LW'(cfg_q);
    end
  end

  // Intake bookkeeping for the word being accepted.
  logic                 in_acc;
  logic [WA-1:0]        widx_new;
  logic [LW-1:0]        fill_new;
  logic [POS_BITS-1:0]  pos_new;
  logic [LW:0]          base_sum;
  logic [LW:0]          base_new;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    if (widx_q == WA'(WIN_MAX - 1)) begin
      widx_new = '0;
    end else begin
      widx_new = widx_q + WA'(1);
    end
    if (new_text_i) begin
      fill_new = LW'(1);
      pos_new  = POS_BITS'(1);
    end else begin
      fill_new = (fill_q == LW'(WIN_MAX)) ? fill_q : fill_q + LW'(1);
      pos_new  = pos_q + POS_BITS'(1);
    end
    base_sum = (LW+1)'(widx_new) + (LW+1)'(WIN_MAX) - (LW+1)'(len_eff);
    if (base_sum >= (LW+1)'(WIN_MAX)) begin
      base_new = base_sum - (LW+1)'(WIN_MAX);
    end else begin
      base_new = base_sum;
    end
  end

  // Scan arithmetic on the current registers.
  logic [JW-1:0]        jm;
  logic [JW-1:0]        km;
  logic [JW-1:0]        lp_x;
  logic [JW-1:0]        k_tl;
  logic signed [IS-1:0] i_eff;
  logic                 i_bad;
  logic                 sj_lt;
  logic                 scan_last;

  always_comb begin
    jm        = mod_n((JW+1)'(j_q), n_q);
    km        = mod_n((JW+1)'(k_q), n_q);
    lp_x      = mod_n((JW+1)'(k_q) + (JW+1)'(i_q[JW-1:0]) + (JW+1)'(1), n_q);
    i_eff     = (i_q < NEG1) ? NEG1 : i_q;
    i_bad     = i_q[IS-1] || (i_q >= $signed({1'b0, nd_q}));
    sj_lt     = (sj_q < win_rdata_q);
    k_tl      = (sj_lt && (sj_q != win_rdata_q)) ? j_q : k_q;
    scan_last = (j_q == nd_q - JW'(1));
  end

  // Memory addresses and failure-link writes.
  always_comb begin
    case (state_q)
      ST_LP_A: win_raddr = phys(base_q, lp_x);
      ST_TL_A: win_raddr = phys(base_q, km);
      default: win_raddr = phys(base_q, jm);
    endcase
    case (state_q)
      ST_LP_W: fail_raddr = i_q[FA-1:0];
      default: fail_raddr = FA'(j_q - k_q - JW'(1));
    endcase
    fail_we    = 1'b0;
    fail_waddr = FA'(j_q - k_q);
    fail_wdata = NEG1;
    case (state_q)
      ST_CLR: begin
        fail_we    = 1'b1;
        fail_waddr = FA'(j_q);
      end
      ST_TL_A: begin
        fail_we    = (i_eff != NEG1);
        fail_wdata = i_eff + IS'(1);
      end
      ST_TL_W: begin
        fail_we = 1'b1;
        if (sj_q != win_rdata_q) begin
          fail_waddr = FA'(j_q - k_tl);
        end else begin
          fail_wdata = '0;
        end
      end
      default: fail_we = 1'b0;
    endcase
  end

  // Circular byte memory: written on intake, read during the scan.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      win_mem[widx_q] <= text_byte_i;
    end
    win_rdata_q <= win_mem[win_raddr];
  end

  // Failure-link memory.
  always_ff @(posedge clk_i) begin
    if (fail_we) begin
      fail_mem[fail_waddr] <= fail_wdata;
    end
    fail_rdata_q <= fail_mem[fail_raddr];
  end

  // Result formed from the final candidate.
  logic [POS_BITS-1:0]          anchor_sum;
  logic [POS_BITS+31:0]         anchor_ext;
  logic [JW+wlra_pkg::OFFSET_W-1:0] offset_ext;
  always_comb begin
    anchor_sum = wstart_q + POS_BITS'(km);
    anchor_ext = {32'b0, anchor_sum};
    offset_ext = {{wlra_pkg::OFFSET_W{1'b0}}, km};
  end

  // A finished result enters the output register once it is free or being taken.
  logic res_load;
  assign res_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Sequencer, position state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= wlra_pkg::LEN_RESET;
      widx_q      <= '0;
      fill_q      <= '0;
      pos_q       <= '0;
      wstart_q    <= '0;
      out_valid_q <= 1'b0;
      n_q         <= LW'(1);
      nd_q        <= JW'(2);
      base_q      <= '0;
      j_q         <= '0;
      k_q         <= '0;
      i_q         <= NEG1;
      sj_q        <= '0;
      anchor_q    <= '0;
      offset_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i && !res_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            widx_q <= widx_new;
            fill_q <= fill_new;
            pos_q  <= pos_new;
            if (fill_new >= len_eff) begin
              wstart_q <= pos_new - POS_BITS'(len_eff);
              n_q      <= len_eff;
              nd_q     <= JW'({len_eff, 1'b0});
              base_q   <= base_new[WA-1:0];
              j_q      <= '0;
              state_q  <= ST_CLR;
            end
          end
        end
        ST_CLR: begin
          if (scan_last) begin
            j_q     <= JW'(1);
            k_q     <= '0;
            state_q <= ST_SJ_A;
          end else begin
            j_q <= j_q + JW'(1);
          end
        end
        ST_SJ_A: state_q <= ST_SJ_W;
        ST_SJ_W: begin
          sj_q    <= win_rdata_q;
          i_q     <= fail_rdata_q;
          state_q <= ST_LP_A;
        end
        ST_LP_A: begin
          state_q <= (i_q == NEG1) ? ST_TL_A : ST_LP_W;
        end
        ST_LP_W: begin
          if (sj_q == win_rdata_q) begin
            state_q <= ST_TL_A;
          end else begin
            if (sj_lt) begin
              k_q <= j_q - i_q[JW-1:0] - JW'(1);
            end
            state_q <= i_bad ? ST_TL_A : ST_LP_F;
          end
        end
        ST_LP_F: begin
          i_q     <= (fail_rdata_q >= i_q) ? NEG1 : fail_rdata_q;
          state_q <= ST_LP_A;
        end
        ST_TL_A: begin
          if (i_eff == NEG1) begin
            state_q <= ST_TL_W;
          end else begin
            j_q     <= j_q + JW'(1);
            state_q <= scan_last ? ST_DONE : ST_SJ_A;
          end
        end
        ST_TL_W: begin
          k_q     <= k_tl;
          j_q     <= j_q + JW'(1);
          state_q <= scan_last ? ST_DONE : ST_SJ_A;
        end
        ST_DONE: begin
          if (res_load) begin
            anchor_q    <= anchor_ext[wlra_pkg::ANCHOR_W-1:0];
            offset_q    <= offset_ext[wlra_pkg::OFFSET_W-1:0];
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign anchor_position_o = anchor_q;
  assign rotation_offset_o = offset_q;

  // The candidate start never runs ahead of the scan position.
  a_k_le_j: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_CLR && state_q != ST_DONE) |-> (k_q <= j_q))
    else $error("least-rotation candidate beyond scan position");

  // The scan position stays inside the doubled window.
  a_j_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_DONE) |-> (j_q < nd_q))
    else $error("scan position outside doubled window");

  // A word that fills the window starts the clearing pass.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (fill_new >= len_eff)) |=> (state_q == ST_CLR))
    else $error("full window did not start a scan");

  // A word that leaves the window short yields no work.
  a_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (fill_new < len_eff)) |=> (state_q == ST_IDLE))
    else $error("short window left the idle state");

  // A finished result waits while the output register is still occupied.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !out_ready_i) |=> (state_q == ST_DONE))
    else $error("result overwrote an untaken word");

endmodule

// ===== tb/window_least_rotation_anchors_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window least-rotation anchors core: self-checking testbench
// Streams text bytes into the core under several window lengths, predicts
// each anchor with a local copy of the least-rotation scan over the doubled
// window and compares every output word against the oldest predicted anchor.
// ----------------------------------------------------------------------------
module window_least_rotation_anchors_core_test;

  localparam int WIN_MAX       = 64;
  localparam int POS_BITS      = 32;
  localparam int SETTLE_CYCLES = 20 * WIN_MAX;
  localparam int CYCLE_LIMIT   = 4000000;

  // Kinds of entry in the stimulus queue.
  typedef enum logic {ENTRY_BYTE, ENTRY_LENGTH} entry_kind_e;

  // Shapes of generated text.
  typedef enum int {MODE_NOISE, MODE_BINARY, MODE_PERIODIC, MODE_CONSTANT, MODE_EXTREMES}
    text_mode_e;

  typedef struct packed {
    entry_kind_e kind;
    logic [7:0]  data;
    logic        restart;
    logic [7:0]  gap;
    logic        drain;
  } stim_entry_t;

  typedef struct packed {
    logic [wlra_pkg::ANCHOR_W-1:0] anchor;
    logic [wlra_pkg::OFFSET_W-1:0] offset;
  } anchor_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [wlra_pkg::CFG_W-1:0]    cfg_wdata_i = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic [wlra_pkg::BYTE_W-1:0]   text_byte_i = '0;
  logic                          new_text_i  = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [wlra_pkg::ANCHOR_W-1:0] anchor_position_o;
  logic [wlra_pkg::OFFSET_W-1:0] rotation_offset_o;

  stim_entry_t pending [$];
  anchor_t     anchors_due [$];
  int          failures    = 0;
  int          cycle_count = 0;

  // Local copy of the core's state and its window length register.
  logic [7:0]                 text_store [WIN_MAX];
  logic [7:0]                 rot_win [WIN_MAX];
  int                         fail_links [2*WIN_MAX];
  int                         store_idx  = 0;
  int                         fill_count = 0;
  logic [31:0]                text_pos   = '0;
  logic [wlra_pkg::CFG_W-1:0] window_cfg = wlra_pkg::LEN_RESET;

  window_least_rotation_anchors_core #(
    .WIN_MAX (WIN_MAX),
    .POS_BITS(POS_BITS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .text_byte_i      (text_byte_i),
    .new_text_i       (new_text_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .anchor_position_o(anchor_position_o),
    .rotation_offset_o(rotation_offset_o)
  );

  always #10 clk_i = ~clk_i;

  // Mostly short idle gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Booth's scan over the doubled window held in rot_win[0..n-1]; returns the
  // offset of the least rotation, the lowest one among equal rotations.
  function automatic int least_rotation(input int n);
    int         span, k, j, i, idx, nxt;
    logic       stop;
    logic [7:0] cur;
    span = 2 * n;
    k    = 0;
    for (j = 0; j < span; j++) fail_links[j] = -1;
    for (j = 1; j < span; j++) begin
      cur  = rot_win[j % n];
      idx  = j - k - 1;
      i    = (idx >= 0 && idx < span) ? fail_links[idx] : -1;
      stop = 1'b0;
      // Follow failure links while the new byte disagrees with the prefix.
      while (!stop && i != -1 && cur != rot_win[(k + i + 1) % n]) begin
        if (cur < rot_win[(k + i + 1) % n]) k = j - i - 1;
        if (i < 0 || i >= span) begin
          stop = 1'b1;
        end else begin
          nxt = fail_links[i];
          if (nxt >= i) nxt = -1;
          i = nxt;
        end
      end
      if (i < -1) i = -1;
      idx = j - k;
      if (i == -1 && cur != rot_win[k % n]) begin
        if (cur < rot_win[k % n]) k = j;
        idx = j - k;
        if (idx >= 0 && idx < span) fail_links[idx] = -1;
      end else begin
        if (idx >= 0 && idx < span) fail_links[idx] = i + 1;
      end
    end
    return (k >= 0) ? k % n : 0;
  endfunction

  // Advances the local state by one accepted word and queues its anchor.
  task automatic predict_anchor(input logic [7:0] text_byte, input logic restart);
    int      len, m, rot;
    anchor_t due;
    len = (window_cfg == 0) ? 1 : (window_cfg > WIN_MAX) ? WIN_MAX : int'(window_cfg);
    if (restart) begin
      text_pos   = '0;
      fill_count = 0;
    end
    text_store[store_idx] = text_byte;
    store_idx = (store_idx + 1) % WIN_MAX;
    text_pos  = text_pos + 32'd1;
    if (fill_count < WIN_MAX) fill_count++;
    if (fill_count >= len) begin
      for (m = 0; m < len; m++) rot_win[m] = text_store[(store_idx + WIN_MAX - len + m) % WIN_MAX];
      rot        = least_rotation(len);
      due.offset = rot[wlra_pkg::OFFSET_W-1:0];
      due.anchor = text_pos - 32'(len) + 32'(rot);
      anchors_due.insert(anchors_due.size(), due);
    end
  endtask

  task automatic add_entry(input entry_kind_e kind, input int data, input logic restart,
                           input int gap, input logic drain);
    stim_entry_t e;
    e.kind    = kind;
    e.data    = data[7:0];
    e.restart = restart;
    e.gap     = gap[7:0];
    e.drain   = drain;
    pending.insert(pending.size(), e);
  endtask

  function automatic int phase_length(input int phase);
    case (phase)
      0:  return 1;
      1:  return 2;
      2:  return 64;
      3:  return 5;
      4:  return 3;
      5:  return 127;
      6:  return 8;
      7:  return 16;
      8:  return 4;
      9:  return 65;
      10: return 11;
      11: return 6;
      12: return 33;
      13: return 13;
      14: return 7;
      15: return 2;
      default: return 9;
    endcase
  endfunction

  // Sender: presents queued words, idles between them and performs the
  // register writes once the core has gone quiet.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    stim_entry_t head;
    logic        next_valid;
    logic        next_we;
    int          settle_count;
    int          gap_left;
    logic        head_armed;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      cfg_we_i     <= 1'b0;
      settle_count = 0;
      gap_left     = 0;
      head_armed   = 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) predict_anchor(text_byte_i, new_text_i);
      next_valid = in_valid_i && !in_ready_o;
      next_we    = 1'b0;
      if (!next_valid && pending.size() != 0) begin
        head = pending[0];
        if (head.kind == ENTRY_LENGTH) begin
          // Only write once no anchor is owed and the last word has settled.
          if (anchors_due.size() != 0) begin
            settle_count = 0;
          end else if (settle_count < SETTLE_CYCLES) begin
            settle_count++;
          end else begin
            next_we      = 1'b1;
            cfg_wdata_i  <= head.data[wlra_pkg::CFG_W-1:0];
            window_cfg   = head.data[wlra_pkg::CFG_W-1:0];
            settle_count = 0;
            head         = pending.pop_front();
          end
        end else begin
          if (!head_armed) begin
            gap_left   = int'(head.gap);
            head_armed = 1'b1;
          end
          if (gap_left != 0) begin
            gap_left--;
          end else if (!head.drain || anchors_due.size() == 0) begin
            next_valid  = 1'b1;
            text_byte_i <= head.data;
            new_text_i  <= head.restart;
            head_armed  = 1'b0;
            head        = pending.pop_front();
          end
        end
      end
      in_valid_i <= next_valid;
      cfg_we_i   <= next_we;
    end
  end

  // Receiver: checks each output word and stalls at random, with calm spells.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    anchor_t due;
    int      stall_left;
    int      calm_left;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  = 0;
      calm_left   = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (anchors_due.size() == 0) begin
          $error("unexpected output word: anchor_position %0d, rotation_offset %0d",
                 anchor_position_o, rotation_offset_o);
          failures++;
        end else begin
          due = anchors_due.pop_front();
          if (anchor_position_o !== due.anchor) begin
            $error("anchor_position: expected %0d, got %0d", due.anchor, anchor_position_o);
            failures++;
          end
          if (rotation_offset_o !== due.offset) begin
            $error("rotation_offset: expected %0d, got %0d", due.offset, rotation_offset_o);
            failures++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (calm_left != 0) calm_left--;
        else if ($urandom_range(0, 63) == 0) calm_left = $urandom_range(40, 240);
        else stall_left = pick_gap();
      end
    end
  end

  // Ends the run if the core stops making progress.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Builds the stimulus, releases reset and waits for the core to drain.
  initial begin : stimulus
    // Opening text, first byte in the lowest bits.
    logic [159:0] opening;
    logic [7:0]   pat [8];
    logic [7:0]   b;
    text_mode_e   mode;
    int           d, phase, n, count, drain_at, m, r, run, period, p;
    logic         calm;
    opening = 160'h4242_FF00_0120_1010_FFFF_0000_AA55_FE01_7F80_00FF;

    // Directed: extremes at the reset length of 16, a restart with a full
    // window, then a zero length, which acts as one, on a run of equal bytes.
    for (d = 0; d < 20; d++) add_entry(ENTRY_BYTE, int'(opening[8*d +: 8]), d == 0 || d == 18,
                                       pick_gap(), 1'b0);
    add_entry(ENTRY_LENGTH, 0, 1'b0, 0, 1'b0);
    for (d = 0; d < 4; d++) add_entry(ENTRY_BYTE, 'h5A, 1'b0, pick_gap(), 1'b0);

    // Random phases: most at short lengths, a few at the largest and beyond.
    // Each phase changes the length mid-text and holds one drain pause.
    for (phase = 0; phase < 17; phase++) begin
      n = phase_length(phase);
      add_entry(ENTRY_LENGTH, n, 1'b0, 0, 1'b0);
      count    = (n > 20) ? 35 : 46;
      drain_at = $urandom_range(5, count - 1);
      m = 0;
      while (m < count) begin
        mode   = text_mode_e'($urandom_range(0, 4));
        run    = $urandom_range(4, 24);
        period = $urandom_range(1, 6);
        calm   = ($urandom_range(0, 3) == 0);
        for (p = 0; p < 8; p++) pat[p] = 8'($urandom_range(0, 255));
        for (r = 0; r < run && m < count; r++) begin
          case (mode)
            MODE_NOISE:    b = 8'($urandom_range(0, 255));
            MODE_BINARY:   b = $urandom_range(0, 1) ? pat[0] : pat[1];
            MODE_PERIODIC: b = pat[r % period];
            MODE_CONSTANT: b = pat[0];
            default:       b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          endcase
          add_entry(ENTRY_BYTE, int'(b), n <= 20 && $urandom_range(0, 39) == 0,
                    calm ? 0 : pick_gap(), m == drain_at);
          m++;
        end
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || in_valid_i) @(posedge clk_i);
    while (anchors_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (failures == 0 && anchors_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
